>>> design/ubx_fb_pkg.sv
// shared types and constants of the ubx frame builder
`default_nettype none
package ubx_fb_pkg;

  // input command codes
  localparam logic CmdStart   = 1'b0;
  localparam logic CmdPayload = 1'b1;

  // frame sync bytes
  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;

  // job queue between front and back
  localparam int QDepth  = 2;
  localparam int QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCountW = $clog2(QDepth + 1);

  // beat counter inside one job (header plus tail is eight beats)
  localparam int StepW = 3;

  typedef struct packed {
    logic        command;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
    logic       misuse;
  } out_item_t;

  typedef enum logic [1:0] {
    JobHeader,
    JobPayload,
    JobMisuse
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic        last;         // header with zero length, or final payload byte
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;
  } job_t;

endpackage
`default_nettype wire

>>> design/ubx_fb_front.sv
// front end: accepts items, tracks frame state and classifies them into jobs
`default_nettype none
module ubx_fb_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  ubx_fb_pkg::in_item_t  in_item_i,
  output logic                  job_valid_o,
  input  wire                   job_ready_i,
  output ubx_fb_pkg::job_t      job_o
);

  logic        frame_open_q, frame_open_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic        accept;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i & job_ready_i;

  always_comb begin
    frame_open_d      = frame_open_q;
    bytes_left_d      = bytes_left_q;
    job_o.kind        = ubx_fb_pkg::JobMisuse;
    job_o.last        = 1'b0;
    job_o.msg_class   = in_item_i.msg_class;
    job_o.msg_id      = in_item_i.msg_id;
    job_o.payload_len = in_item_i.payload_len;
    job_o.data_byte   = in_item_i.data_byte;
    if (in_item_i.command == ubx_fb_pkg::CmdStart) begin
      if (!frame_open_q) begin
        job_o.kind = ubx_fb_pkg::JobHeader;
        job_o.last = (in_item_i.payload_len == 16'd0);
        if (accept && !job_o.last) begin
          frame_open_d = 1'b1;
          bytes_left_d = in_item_i.payload_len;
        end
      end
    end else if (frame_open_q) begin
      job_o.kind = ubx_fb_pkg::JobPayload;
      job_o.last = (bytes_left_q == 16'd1);
      if (accept) begin
        bytes_left_d = bytes_left_q - 16'd1;
        frame_open_d = !job_o.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_left_q <= '0;
    end else begin
      frame_open_q <= frame_open_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  // an open frame always has bytes still to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_open_q |-> (bytes_left_q != 16'd0))
    else $error("open frame with no bytes left");

  // a payload job is only issued inside an open frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && job_o.kind == ubx_fb_pkg::JobPayload) |-> frame_open_q)
    else $error("payload job outside a frame");

  // a frame closes after its final payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && job_o.kind == ubx_fb_pkg::JobPayload && job_o.last) |=> !frame_open_q)
    else $error("frame still open after final byte");

endmodule
`default_nettype wire

>>> design/ubx_fb_queue.sv
// short job queue between front and back
`default_nettype none
module ubx_fb_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_valid_i,
  output logic              push_ready_o,
  input  ubx_fb_pkg::job_t  push_job_i,
  output logic              pop_valid_o,
  input  wire               pop_i,
  output ubx_fb_pkg::job_t  pop_job_o
);

  ubx_fb_pkg::job_t                    slots_q [ubx_fb_pkg::QDepth];
  logic [ubx_fb_pkg::QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [ubx_fb_pkg::QCountW-1:0]      count_q;
  logic                                push, pop;

  localparam logic [ubx_fb_pkg::QPtrW-1:0] LastPtr =
    ubx_fb_pkg::QPtrW'(ubx_fb_pkg::QDepth - 1);
  localparam logic [ubx_fb_pkg::QCountW-1:0] FullCount =
    ubx_fb_pkg::QCountW'(ubx_fb_pkg::QDepth);

  assign push_ready_o = (count_q != FullCount);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_i & pop_valid_o;
  assign pop_job_o    = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/ubx_fb_back.sv
// back end: serializes jobs into frame bytes and keeps the fletcher sums
`default_nettype none
module ubx_fb_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    job_valid_i,
  input  ubx_fb_pkg::job_t       job_i,
  output logic                   job_pop_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output ubx_fb_pkg::out_item_t  out_item_o
);

  logic [ubx_fb_pkg::StepW-1:0] step_q;
  logic [7:0]                   sum_a_q, sum_b_q;
  logic [7:0]                   sum_a_add;
  logic                         out_valid_q;
  ubx_fb_pkg::out_item_t        out_item_q;
  ubx_fb_pkg::out_item_t        beat;
  logic                         fire, last_beat, add_en, clr_sums;
  logic [7:0]                   add_byte;

  assign fire      = job_valid_i & (!out_valid_q | out_ready_i);
  assign job_pop_o = fire & last_beat;
  assign sum_a_add = sum_a_q + add_byte;

  always_comb begin
    beat      = '0;
    last_beat = 1'b0;
    add_en    = 1'b0;
    clr_sums  = 1'b0;
    add_byte  = '0;
    unique case (job_i.kind)
      ubx_fb_pkg::JobHeader: begin
        unique case (step_q)
          3'd0: begin
            beat.out_byte = ubx_fb_pkg::SyncFirst;
            clr_sums      = 1'b1;
          end
          3'd1: beat.out_byte = ubx_fb_pkg::SyncSecond;
          3'd2: begin
            beat.out_byte = job_i.msg_class;
            add_en        = 1'b1;
          end
          3'd3: begin
            beat.out_byte = job_i.msg_id;
            add_en        = 1'b1;
          end
          3'd4: begin
            beat.out_byte = job_i.payload_len[7:0];
            add_en        = 1'b1;
          end
          3'd5: begin
            beat.out_byte = job_i.payload_len[15:8];
            beat.run_last = !job_i.last;
            last_beat     = !job_i.last;
            add_en        = 1'b1;
          end
          3'd6: beat.out_byte = sum_a_q;
          3'd7: begin
            beat.out_byte  = sum_b_q;
            beat.frame_end = 1'b1;
            beat.run_last  = 1'b1;
            last_beat      = 1'b1;
            clr_sums       = 1'b1;
          end
        endcase
      end
      ubx_fb_pkg::JobPayload: begin
        unique case (step_q)
          3'd0: begin
            beat.out_byte = job_i.data_byte;
            beat.run_last = !job_i.last;
            last_beat     = !job_i.last;
            add_en        = 1'b1;
          end
          3'd1: beat.out_byte = sum_a_q;
          default: begin
            beat.out_byte  = sum_b_q;
            beat.frame_end = 1'b1;
            beat.run_last  = 1'b1;
            last_beat      = 1'b1;
            clr_sums       = 1'b1;
          end
        endcase
      end
      default: begin
        // misuse: one flagged beat, no byte
        beat.misuse   = 1'b1;
        beat.run_last = 1'b1;
        last_beat     = 1'b1;
      end
    endcase
    if (add_en) begin
      add_byte = beat.out_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        step_q <= last_beat ? '0 : step_q + 1'b1;
        if (clr_sums) begin
          sum_a_q <= '0;
          sum_b_q <= '0;
        end else if (add_en) begin
          sum_a_q <= sum_a_add;
          sum_b_q <= sum_b_q + sum_a_add;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // mid-job the job must still sit at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> job_valid_i)
    else $error("job left the queue before its last beat");

  // the closing checksum byte ends the beat run of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.frame_end) |-> out_item_o.run_last)
    else $error("frame end without run last");

  // a flagged beat carries no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.misuse) |-> (out_item_o.out_byte == 8'd0 &&
                                            !out_item_o.frame_end))
    else $error("misuse beat with data");

  // a stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled output beat changed");

endmodule
`default_nettype wire

>>> design/ubx_frame_builder.sv
// top level of the ubx frame builder: front, job queue and byte serializer
//
// usage
//   in channel (in_valid_i / in_ready_o / in_item_i): one beat per command.
//   command start carries class, id and payload length; command payload
//   carries one data byte. out channel (out_valid_o / out_ready_i /
//   out_item_o) gives one frame byte per beat, with frame_end on checksum b
//   and run_last on the last beat caused by each input beat.
//   a start beat yields sync 0xb5 0x62, class, id, length low, length high
//   (plus checksum a and b when the length is zero); a payload beat yields
//   its byte (plus checksum a and b after the final byte). a start inside an
//   open frame, or a payload beat outside one, yields a single misuse beat.
// timing
//   the first output beat of an item passes from its input beat through
//   the job queue into the registered output beat of the serializer. the
//   serializer emits one byte per cycle while the receiver keeps up.
//   a two-entry job queue sits between the front and the serializer, so
//   payload beats flow at one per cycle while the receiver keeps up, and the
//   input stalls during header and checksum bursts or a receiver stall.
// reset and stall
//   reset closes any frame, clears both sums and empties the queue and the
//   output register. a stalled receiver holds the current output beat; the
//   queue then fills and in_ready_o drops until beats move again.
`default_nettype none
module ubx_frame_builder (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  ubx_fb_pkg::in_item_t   in_item_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output ubx_fb_pkg::out_item_t  out_item_o
);

  // front to queue
  logic             fq_valid, fq_ready;
  ubx_fb_pkg::job_t fq_job;
  // queue to back
  logic             qb_valid, qb_pop;
  ubx_fb_pkg::job_t qb_job;

  // frame state tracking and command classification
  ubx_fb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  // decouples classification from byte serialization
  ubx_fb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_job_i   (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_i        (qb_pop),
    .pop_job_o    (qb_job)
  );

  // byte serializer with fletcher sums and registered output beat
  ubx_fb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_i       (qb_job),
    .job_pop_o   (qb_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire
